// ===== hdl/crcdf_pkg.sv =====
// Shared types, register indexes and the CRC byte update for the packet deframer.
// Used by the front parser, the back checker and the top level. No dependencies.
package crcdf_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd2;

  localparam logic [7:0]  ALIGN_RESET = 8'h00;
  localparam logic [15:0] POLY_RESET  = 16'h1021;
  localparam logic [15:0] SEED_RESET  = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_ALIGN   = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC_LO  = 3'd3,
    PH_CRC_HI  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_BADSYNC = 3'd1,
    OP_LEN     = 3'd2,
    OP_PAYLOAD = 3'd3,
    OP_CRC_LO  = 3'd4,
    OP_CRC_HI  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_GOOD    = 2'd1,
    ST_BADSYNC = 2'd2,
    ST_BADCRC  = 2'd3
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } qitem_t;

  typedef struct packed {
    logic [7:0]  align;
    logic [15:0] poly;
    logic [15:0] seed;
  } cfg_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ poly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/crcdf_fifo.sv =====
// Small register queue that decouples the frame parser from the CRC checker.
// Generic width and depth; no package dependencies.
module crcdf_fifo #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem_r [DEPTH];
  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/crcdf_front.sv =====
// Frame parser: tracks the frame layout and tags each received byte with its role.
// Depends on crcdf_pkg for the phase, operation and configuration types.
module crcdf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  input  crcdf_pkg::cfg_t cfg,
  output crcdf_pkg::qitem_t item
);
  import crcdf_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] left_dec;

  assign left_dec = bytes_left_r - 8'd1;

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    unique case (phase_r)
      PH_LEN: begin
        bytes_left_nxt = rx_byte;
        phase_nxt      = (rx_byte == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        bytes_left_nxt = left_dec;
        if (left_dec == 8'd0) begin
          phase_nxt = PH_CRC_LO;
        end
      end
      PH_CRC_LO: phase_nxt = PH_CRC_HI;
      PH_CRC_HI: phase_nxt = PH_ALIGN;
      default: begin
        phase_nxt = (rx_byte == cfg.align) ? PH_LEN : PH_ALIGN;
      end
    endcase
  end

  always_comb begin
    item.data = rx_byte;
    unique case (phase_r)
      PH_LEN:     item.op = OP_LEN;
      PH_PAYLOAD: item.op = OP_PAYLOAD;
      PH_CRC_LO:  item.op = OP_CRC_LO;
      PH_CRC_HI:  item.op = OP_CRC_HI;
      default:    item.op = (rx_byte == cfg.align) ? OP_START : OP_BADSYNC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_ALIGN;
      bytes_left_r <= '0;
    end else if (take) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

// ===== hdl/crcdf_back.sv =====
// CRC checker: runs the CRC over tagged bytes and builds one result item per byte.
// Depends on crcdf_pkg for the operation and status codes and the CRC update.
module crcdf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  crcdf_pkg::qitem_t item,
  input  logic              item_valid,
  output logic              item_take,
  input  crcdf_pkg::cfg_t   cfg,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_payload_byte,
  output logic              out_payload_valid,
  output logic              out_frame_end,
  output logic [1:0]        out_frame_status
);
  import crcdf_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        out_valid_r;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic        pvalid_r, pvalid_nxt;
  logic        fend_r, fend_nxt;
  status_t     stat_r, stat_nxt;
  logic [15:0] crc_base;
  logic [15:0] crc_upd;

  assign item_take = item_valid && (!out_valid_r || out_pop);
  assign crc_base  = (item.op == OP_START) ? cfg.seed : crc_r;
  assign crc_upd   = crc_feed(crc_base, item.data, cfg.poly);

  always_comb begin
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    pbyte_nxt  = 8'd0;
    pvalid_nxt = 1'b0;
    fend_nxt   = 1'b0;
    stat_nxt   = ST_BUSY;
    unique case (item.op)
      OP_START: crc_nxt = crc_upd;
      OP_LEN:   crc_nxt = crc_upd;
      OP_PAYLOAD: begin
        crc_nxt    = crc_upd;
        pbyte_nxt  = item.data;
        pvalid_nxt = 1'b1;
      end
      OP_CRC_LO: crc_lo_nxt = item.data;
      OP_CRC_HI: begin
        fend_nxt = 1'b1;
        stat_nxt = ({item.data, crc_lo_r} == crc_r) ? ST_GOOD : ST_BADCRC;
      end
      OP_BADSYNC: begin
        fend_nxt = 1'b1;
        stat_nxt = ST_BADSYNC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      crc_r       <= '0;
      crc_lo_r    <= '0;
    end else begin
      if (item_take) begin
        out_valid_r <= 1'b1;
        crc_r       <= crc_nxt;
        crc_lo_r    <= crc_lo_nxt;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      pbyte_r  <= pbyte_nxt;
      pvalid_r <= pvalid_nxt;
      fend_r   <= fend_nxt;
      stat_r   <= stat_nxt;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_payload_byte  = pbyte_r;
  assign out_payload_valid = pvalid_r;
  assign out_frame_end     = fend_r;
  assign out_frame_status  = stat_r;

endmodule

// ===== hdl/crc16_packet_deframer.sv =====
// Top level of the length-prefixed frame deframer with CRC-16 check.
// Holds the configuration registers and joins crcdf_front, crcdf_fifo and crcdf_back.
//
//   channel   handshake        payload
//   input     in_push/in_full  in_rx_byte
//   result    out_pop/out_empty out_payload_byte, out_payload_valid,
//                              out_frame_end, out_frame_status
//   config    cfg_we           cfg_index, cfg_wdata
//
// One item is taken per cycle while in_full is low; it passes through the queue and its
// result item is registered in the checker. The byte-wide CRC update there sets that rate.
// Reset is synchronous and clears the parser, queue and result register.
// A stalled result holds in its register while up to QUEUE_DEPTH items wait behind it.
module crc16_packet_deframer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [7:0]                         in_rx_byte,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [7:0]                         out_payload_byte,
  output logic                               out_payload_valid,
  output logic                               out_frame_end,
  output logic [1:0]                         out_frame_status,
  input  logic                               cfg_we,
  input  logic [crcdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crcdf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import crcdf_pkg::*;

  cfg_t   cfg_r;
  qitem_t f_item;
  qitem_t b_item;
  logic   take;
  logic   q_empty;
  logic   b_take;
  logic [$bits(qitem_t)-1:0] q_rdata;

  assign take   = in_push && !in_full;
  assign b_item = qitem_t'(q_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.align <= ALIGN_RESET;
      cfg_r.poly  <= POLY_RESET;
      cfg_r.seed  <= SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALIGN: cfg_r.align <= cfg_wdata[7:0];
        CFG_POLY:  cfg_r.poly  <= cfg_wdata;
        CFG_SEED:  cfg_r.seed  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  crcdf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .item    (f_item)
  );

  crcdf_fifo #(
    .WIDTH ($bits(qitem_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (f_item),
    .full  (in_full),
    .pop   (b_take),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  crcdf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item              (b_item),
    .item_valid        (!q_empty),
    .item_take         (b_take),
    .cfg               (cfg_r),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_payload_byte  (out_payload_byte),
    .out_payload_valid (out_payload_valid),
    .out_frame_end     (out_frame_end),
    .out_frame_status  (out_frame_status)
  );

endmodule

// ===== hdl/crcdf_checker.sv =====
// Port-level checks on the deframer's result channel, bound to the top level.
// Depends on crcdf_pkg for the status codes.
module crcdf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_payload_byte,
  input logic       out_payload_valid,
  input logic       out_frame_end,
  input logic [1:0] out_frame_status
);
  import crcdf_pkg::*;

  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_frame_end == (out_frame_status != ST_BUSY)))
    else $error("frame_end and frame_status disagree");

  a_payload_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_payload_valid && out_frame_end))
    else $error("payload item also ends a frame");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_payload_valid) |-> (out_payload_byte == 8'd0))
    else $error("non-payload item carries a payload byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_payload_byte)
      && $stable(out_payload_valid) && $stable(out_frame_end)
      && $stable(out_frame_status)))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result channel not empty after reset");

endmodule

bind crc16_packet_deframer crcdf_checker u_checker (.*);
